// ===== design/hlc_pkg.sv =====
// ----------------------------------------------------------------------------
// hlc_pkg
// Shared types and constants for the host literal classifier.
// ----------------------------------------------------------------------------
package hlc_pkg;

    // Default for the longest host string held before overflow
    localparam int unsigned MAX_LEN_DEFAULT = 255;

    // Output buffer size after reset
    localparam logic [8:0] OUT_SIZE_RESET = 9'd256;

    // Longest kept text that the result can report
    localparam int unsigned TEXT_LEN_MAX = 255;

    // Largest value of one dotted-quad field
    localparam logic [9:0] QUAD_FIELD_MAX = 10'd255;

    // Field limits of the dotted quad
    localparam logic [1:0] QUAD_DIGITS_MAX = 2'd3;
    localparam logic [2:0] QUAD_FIELDS_SAT = 3'd5;
    localparam logic [3:0] QUAD_FIELDS_REQ = 4'd4;

    // Colon count saturates here
    localparam logic [1:0] COLON_SAT = 2'd2;

    typedef logic [7:0] char_t;
    typedef logic [8:0] out_size_t;
    typedef logic [7:0] text_len_t;

    // Special characters
    localparam char_t CHAR_ZERO     = 8'h30;
    localparam char_t CHAR_NINE     = 8'h39;
    localparam char_t CHAR_DOT      = 8'h2E;
    localparam char_t CHAR_COLON    = 8'h3A;
    localparam char_t CHAR_LBRACKET = 8'h5B;
    localparam char_t CHAR_RBRACKET = 8'h5D;

    typedef enum logic [1:0] {
        KIND_NAME = 2'd0,
        KIND_IPV4 = 2'd1,
        KIND_IPV6 = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t     kind;
        logic      text_start;
        text_len_t text_length;
    } hlc_result_t;

endpackage

// ===== design/hlc_char_if.sv =====
// ----------------------------------------------------------------------------
// hlc_char_if
// Character channel: one host-string byte per transfer, last on the final one.
// ----------------------------------------------------------------------------
interface hlc_char_if;

    logic           valid;
    logic           ready;
    hlc_pkg::char_t char_code;
    logic           last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);

endinterface

// ===== design/hlc_result_if.sv =====
// ----------------------------------------------------------------------------
// hlc_result_if
// Result channel: kind of host and place of the kept text, one per string.
// ----------------------------------------------------------------------------
interface hlc_result_if;

    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic               text_start;
    hlc_pkg::text_len_t text_length;

    modport source (output valid, output kind, output text_start, output text_length,
                    input ready);
    modport sink   (input valid, input kind, input text_start, input text_length,
                    output ready);

endinterface

// ===== design/hlc_scan.sv =====
// ----------------------------------------------------------------------------
// hlc_scan
// Per-character scan state and the classification of a finished string.
// ----------------------------------------------------------------------------
module hlc_scan #(
    parameter int unsigned MAX_LEN = hlc_pkg::MAX_LEN_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  hlc_pkg::char_t      char_code,
    input  logic                last,
    input  hlc_pkg::out_size_t  out_size,
    output hlc_pkg::hlc_result_t result
);
    import hlc_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int XW = (CW > 9) ? CW : 9;

    typedef logic [CW-1:0] pos_t;

    pos_t       cnt_reg, cnt_next;
    logic       ovf_reg, ovf_next;
    logic       brk_reg, brk_next;
    logic       close_reg, close_next;
    pos_t       close_pos_reg, close_pos_next;
    logic [1:0] colon_reg, colon_next;
    pos_t       colon_pos_reg, colon_pos_next;
    logic [9:0] fval_reg, fval_next;
    logic [1:0] digits_reg, digits_next;
    logic [2:0] qf_reg, qf_next;
    logic       qok_reg, qok_next;

    logic       is_digit;
    logic       quad_good;
    logic [3:0] fields_total;
    logic [XW-1:0] keep_ext;
    logic [XW-1:0] len_ext;

    assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);

    // Fold the incoming character into the scan state
    always_comb
    begin
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        brk_next       = brk_reg;
        close_next     = close_reg;
        close_pos_next = close_pos_reg;
        colon_next     = colon_reg;
        colon_pos_next = colon_pos_reg;
        fval_next      = fval_reg;
        digits_next    = digits_reg;
        qf_next        = qf_reg;
        qok_next       = qok_reg;
        if (cnt_reg >= CW'(MAX_LEN))
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            if ((cnt_reg == '0) && (char_code == CHAR_LBRACKET))
            begin
                brk_next = 1'b1;
            end
            if ((char_code == CHAR_RBRACKET) && !close_reg)
            begin
                close_next     = 1'b1;
                close_pos_next = cnt_reg;
            end
            if (char_code == CHAR_COLON)
            begin
                if (colon_reg == 2'd0)
                begin
                    colon_pos_next = cnt_reg;
                end
                if (colon_reg < COLON_SAT)
                begin
                    colon_next = colon_reg + 2'd1;
                end
            end
            else if (colon_reg == 2'd0)
            begin
                if (is_digit)
                begin
                    if (digits_reg >= QUAD_DIGITS_MAX)
                    begin
                        qok_next = 1'b0;
                    end
                    else
                    begin
                        fval_next   = 10'(fval_reg * 10'd10) + 10'(char_code - CHAR_ZERO);
                        digits_next = digits_reg + 2'd1;
                    end
                end
                else if (char_code == CHAR_DOT)
                begin
                    if ((digits_reg == 2'd0) || (fval_reg > QUAD_FIELD_MAX))
                    begin
                        qok_next = 1'b0;
                    end
                    else if (qf_reg < QUAD_FIELDS_SAT)
                    begin
                        qf_next = qf_reg + 3'd1;
                    end
                    fval_next   = '0;
                    digits_next = 2'd0;
                end
                else
                begin
                    qok_next = 1'b0;
                end
            end
            cnt_next = cnt_reg + pos_t'(1);
        end
    end

    // Check the dotted quad, counting an open final field
    always_comb
    begin
        fields_total = {1'b0, qf_next};
        if (digits_next != 2'd0)
        begin
            fields_total = {1'b0, qf_next} + 4'd1;
        end
        quad_good = qok_next && (fields_total == QUAD_FIELDS_REQ);
        if ((digits_next != 2'd0) && (fval_next > QUAD_FIELD_MAX))
        begin
            quad_good = 1'b0;
        end
    end

    // Classify the string as it stands after this character
    always_comb
    begin
        result.kind       = KIND_NAME;
        result.text_start = 1'b0;
        len_ext           = '0;
        keep_ext          = (colon_next == 2'd1) ? XW'(colon_pos_next) : XW'(cnt_next);
        if (ovf_next || (cnt_next == '0) || (XW'(cnt_next) >= XW'(out_size)))
        begin
            result.kind = KIND_NAME;
        end
        else if (brk_next)
        begin
            if (close_next && (close_pos_next > pos_t'(1)))
            begin
                result.kind       = KIND_IPV6;
                result.text_start = 1'b1;
                len_ext           = XW'(close_pos_next - pos_t'(1));
            end
        end
        else if (colon_next >= COLON_SAT)
        begin
            result.kind = KIND_IPV6;
            len_ext     = XW'(cnt_next);
        end
        else if (keep_ext != '0)
        begin
            len_ext     = keep_ext;
            result.kind = quad_good ? KIND_IPV4 : KIND_NAME;
        end
        result.text_length = (len_ext > XW'(TEXT_LEN_MAX)) ? text_len_t'(TEXT_LEN_MAX)
                                                           : len_ext[7:0];
    end

    // Advance on each character, clear after the final one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            brk_reg       <= 1'b0;
            close_reg     <= 1'b0;
            close_pos_reg <= '0;
            colon_reg     <= 2'd0;
            colon_pos_reg <= '0;
            fval_reg      <= '0;
            digits_reg    <= 2'd0;
            qf_reg        <= 3'd0;
            qok_reg       <= 1'b1;
        end
        else if (step)
        begin
            if (last)
            begin
                cnt_reg       <= '0;
                ovf_reg       <= 1'b0;
                brk_reg       <= 1'b0;
                close_reg     <= 1'b0;
                close_pos_reg <= '0;
                colon_reg     <= 2'd0;
                colon_pos_reg <= '0;
                fval_reg      <= '0;
                digits_reg    <= 2'd0;
                qf_reg        <= 3'd0;
                qok_reg       <= 1'b1;
            end
            else
            begin
                cnt_reg       <= cnt_next;
                ovf_reg       <= ovf_next;
                brk_reg       <= brk_next;
                close_reg     <= close_next;
                close_pos_reg <= close_pos_next;
                colon_reg     <= colon_next;
                colon_pos_reg <= colon_pos_next;
                fval_reg      <= fval_next;
                digits_reg    <= digits_next;
                qf_reg        <= qf_next;
                qok_reg       <= qok_next;
            end
        end
    end

endmodule

// ===== design/host_literal_classifier.sv =====
// ----------------------------------------------------------------------------
// host_literal_classifier
// Classifies a streamed host string as name, IPv4 dotted quad or IPv6 literal.
// ----------------------------------------------------------------------------
// Characters enter one per cycle on chars; the final one carries last, and the
// result (kind, text_start, text_length) then stands on results, held until
// taken. An input register feeds the scan logic, and its outcome goes into a
// result register, so a new string may start in the cycle right after the
// previous one ended while its result still waits. The rate is one character
// per cycle; the input stalls only while a final character is held and the
// previous result still waits untaken. Strings of more than MAX_LEN characters,
// or not shorter than the out_size register (written through cfg_we/cfg_wdata,
// reset 256), report a name with empty text.
// ----------------------------------------------------------------------------
module host_literal_classifier #(
    parameter int unsigned MAX_LEN = hlc_pkg::MAX_LEN_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  hlc_pkg::out_size_t cfg_wdata,
    hlc_char_if.sink           chars,
    hlc_result_if.source       results
);
    import hlc_pkg::*;

    out_size_t   out_size_reg;
    logic        in_valid_reg, in_valid_next;
    char_t       char_reg;
    logic        last_reg;
    logic        out_valid_reg, out_valid_next;
    hlc_result_t res_reg;
    hlc_result_t scan_result;

    logic        out_free;
    logic        advance;
    logic        take;

    // Move the held character on unless its result has nowhere to go
    assign out_free     = !out_valid_reg || results.ready;
    assign advance      = in_valid_reg && (!last_reg || out_free);
    assign chars.ready  = !in_valid_reg || advance;
    assign take         = chars.valid && chars.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    hlc_scan #(
        .MAX_LEN (MAX_LEN)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_code (char_reg),
        .last      (last_reg),
        .out_size  (out_size_reg),
        .result    (scan_result)
    );

    // Hold the buffer size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_size_reg <= OUT_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            out_size_reg <= cfg_wdata;
        end
    end

    // Track valid flags of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the character on each transfer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= chars.char_code;
            last_reg <= chars.last;
        end
    end

    // Capture the result when a string ends
    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            res_reg <= scan_result;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.kind        = res_reg.kind;
    assign results.text_start  = res_reg.text_start;
    assign results.text_length = res_reg.text_length;

endmodule

// ===== design/hlc_checker.sv =====
// ----------------------------------------------------------------------------
// hlc_checker
// Port-level checks of the host literal classifier, bound to its top level.
// ----------------------------------------------------------------------------
module hlc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               chars_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic [1:0]         res_kind,
    input logic               res_text_start,
    input hlc_pkg::text_len_t res_text_length
);
    import hlc_pkg::*;

    // Hold a stalled result unchanged
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind)
            && $stable(res_text_start) && $stable(res_text_length))
        else $error("stalled result changed");

    // Keep the character side open while no result waits
    a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> chars_ready)
        else $error("characters refused with empty result stage");

    // Report a text offset only for bracketed IPv6
    a_start_ipv6: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_text_start |-> res_kind == KIND_IPV6 && res_text_length != 8'd0)
        else $error("text offset on a result that is not bracketed IPv6");

    // Cover at least a shortest dotted quad for IPv4
    a_ipv4_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_IPV4 |-> !res_text_start && res_text_length >= 8'd7)
        else $error("IPv4 result with impossible text");

endmodule

bind host_literal_classifier hlc_checker u_hlc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .chars_ready     (chars.ready),
    .res_valid       (results.valid),
    .res_ready       (results.ready),
    .res_kind        (results.kind),
    .res_text_start  (results.text_start),
    .res_text_length (results.text_length)
);
